// ===== rtl/tcna_pkg.sv =====
package tcna_pkg;

  // Pipeline control that every stage of a submodule sees: advance and the
  // valid bit of the word entering its first stage.
  typedef struct packed {
    logic en;
    logic vld;
  } tcna_ctl_t;

  localparam int unsigned NUM_AXES = 3;

endpackage

// ===== rtl/tcna_isqrt.sv =====
module tcna_isqrt #(
  parameter int RW  = 42,
  parameter int SBW = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tcna_pkg::tcna_ctl_t   ctl,
  input  logic [2*RW-1:0]       rad,
  input  logic [SBW-1:0]        sb_in,
  output logic                  out_vld,
  output logic [RW-1:0]         root,
  output logic [SBW-1:0]        sb_out
);

  localparam int NW = 2 * RW;

  wire [NW-1:0]  x_w   [RW+1];
  wire [NW-1:0]  res_w [RW+1];
  wire [SBW-1:0] sb_w  [RW+1];
  wire           vld_w [RW+1];

  assign x_w[0]   = rad;
  assign res_w[0] = '0;
  assign sb_w[0]  = sb_in;
  assign vld_w[0] = ctl.vld;

  // One result bit per stage; res holds the root scaled by the current weight.
  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam logic [NW-1:0] ONE = NW'(1) << (2 * (RW - 1 - k));
    logic [NW-1:0]  x_r;
    logic [NW-1:0]  res_r;
    logic [SBW-1:0] sb_r;
    logic           vld_r;
    logic [NW-1:0]  trial;
    logic           ge;

    assign trial = res_w[k] + ONE;
    assign ge    = x_w[k] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (ctl.en) begin
        vld_r <= vld_w[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        sb_r <= sb_w[k];
        if (ge) begin
          x_r   <= x_w[k] - trial;
          res_r <= (res_w[k] >> 1) + ONE;
        end else begin
          x_r   <= x_w[k];
          res_r <= res_w[k] >> 1;
        end
      end
    end

    assign x_w[k+1]   = x_r;
    assign res_w[k+1] = res_r;
    assign sb_w[k+1]  = sb_r;
    assign vld_w[k+1] = vld_r;
  end

  assign out_vld = vld_w[RW];
  assign root    = res_w[RW][RW-1:0];
  assign sb_out  = sb_w[RW];

endmodule

// ===== rtl/tcna_div.sv =====
module tcna_div #(
  parameter int NUMW = 55,
  parameter int DENW = 42,
  parameter int QW   = 15,
  parameter int SBW  = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tcna_pkg::tcna_ctl_t        ctl,
  input  logic [2:0][NUMW-1:0]       num,
  input  logic [DENW-1:0]            den,
  input  logic [SBW-1:0]             sb_in,
  output logic                       out_vld,
  output logic [2:0][QW-1:0]         quo,
  output logic [SBW-1:0]             sb_out
);

  localparam int DW = DENW + QW;

  wire [2:0][DW-1:0] rem_w [QW+1];
  wire [2:0][QW-1:0] q_w   [QW+1];
  wire [DENW-1:0]    den_w [QW+1];
  wire [SBW-1:0]     sb_w  [QW+1];
  wire               vld_w [QW+1];

  for (genvar l = 0; l < 3; l++) begin : g_init
    assign rem_w[0][l] = DW'(num[l]);
  end
  assign q_w[0]   = '0;
  assign den_w[0] = den;
  assign sb_w[0]  = sb_in;
  assign vld_w[0] = ctl.vld;

  // Restoring division, one quotient bit per stage, all three lanes side by side.
  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int J = QW - 1 - k;
    logic [2:0][DW-1:0] rem_r;
    logic [2:0][QW-1:0] q_r;
    logic [DENW-1:0]    den_r;
    logic [SBW-1:0]     sb_r;
    logic               vld_r;
    logic [DW-1:0]      dsh;

    assign dsh = DW'(den_w[k]) << J;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (ctl.en) begin
        vld_r <= vld_w[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        den_r <= den_w[k];
        sb_r  <= sb_w[k];
        for (int l = 0; l < 3; l++) begin
          if (rem_w[k][l] >= dsh) begin
            rem_r[l]    <= rem_w[k][l] - dsh;
            q_r[l]      <= q_w[k][l] | (QW'(1) << J);
          end else begin
            rem_r[l]    <= rem_w[k][l];
            q_r[l]      <= q_w[k][l];
          end
        end
      end
    end

    assign rem_w[k+1] = rem_r;
    assign q_w[k+1]   = q_r;
    assign den_w[k+1] = den_r;
    assign sb_w[k+1]  = sb_r;
    assign vld_w[k+1] = vld_r;
  end

  assign out_vld = vld_w[QW];
  assign quo     = q_w[QW];
  assign sb_out  = sb_w[QW];

endmodule

// ===== rtl/triangle_centroid_normal_area_unit.sv =====
// Stages from input word to result word: six arithmetic stages, one square-root stage
// per root bit, one divide stage per quotient bit, one output register. Throughput: one
// triangle per cycle while the result word is not stalled.
// The whole pipeline advances together; it holds while a result word is stalled.
// Reset (rst_n low, synchronous) clears all valid bits; no data is cleared.
module triangle_centroid_normal_area_unit #(
  parameter int COORD_BITS       = 20,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  in_v0_x,
  input  logic signed [COORD_BITS-1:0]  in_v0_y,
  input  logic signed [COORD_BITS-1:0]  in_v0_z,
  input  logic signed [COORD_BITS-1:0]  in_v1_x,
  input  logic signed [COORD_BITS-1:0]  in_v1_y,
  input  logic signed [COORD_BITS-1:0]  in_v1_z,
  input  logic signed [COORD_BITS-1:0]  in_v2_x,
  input  logic signed [COORD_BITS-1:0]  in_v2_y,
  input  logic signed [COORD_BITS-1:0]  in_v2_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_BITS-1:0]  out_centroid_x,
  output logic signed [COORD_BITS-1:0]  out_centroid_y,
  output logic signed [COORD_BITS-1:0]  out_centroid_z,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_normal_x,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_normal_y,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_normal_z,
  output logic [2*COORD_BITS:0]         out_tri_area,
  output logic                          out_degenerate
);

  localparam int CW   = COORD_BITS;
  localparam int NF   = NORMAL_FRAC_BITS;
  localparam int EW   = CW + 1;
  localparam int SW   = CW + 2;
  localparam int PW   = 2 * EW;
  localparam int XW   = PW + 1;
  localparam int AW   = 2 * CW + 1;
  localparam int MW   = AW + 1;
  localparam int QW   = NF + 1;
  localparam int NW   = NF + 2;
  localparam int HL   = (AW + 1) / 2;
  localparam int HH   = AW - HL;
  localparam int SQW  = 2 * AW;
  localparam int RSH  = SW + 1;
  localparam logic [SW-1:0] RECIP3 = SW'(((64'd1 << RSH) + 64'd2) / 64'd3);
  localparam int SB1W = 3 * CW + 3 * AW + 3;
  localparam int SB2W = 3 * CW + 3 + MW;
  localparam logic signed [NW-1:0] NMAX = NW'(1) << NF;

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Stage 1: edges and axis sums.
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];
  logic signed [SW-1:0] sum_r [3];
  logic                 v1_r;
  logic signed [CW-1:0] va [3];
  logic signed [CW-1:0] vb [3];
  logic signed [CW-1:0] vc [3];

  assign va[0] = in_v0_x;
  assign va[1] = in_v0_y;
  assign va[2] = in_v0_z;
  assign vb[0] = in_v1_x;
  assign vb[1] = in_v1_y;
  assign vb[2] = in_v1_z;
  assign vc[0] = in_v2_x;
  assign vc[1] = in_v2_y;
  assign vc[2] = in_v2_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i]  <= EW'(vb[i]) - EW'(va[i]);
        e2_r[i]  <= EW'(vc[i]) - EW'(va[i]);
        sum_r[i] <= SW'(va[i]) + SW'(vb[i]) + SW'(vc[i]);
      end
    end
  end

  // Stage 2: cross-product terms and division of the sums by three.
  logic signed [PW-1:0] p_r [6];
  logic [2*SW-1:0]      cm_r [3];
  logic                 sn_r [3];
  logic                 v2_r;
  logic [SW-1:0]        sabs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sabs[i] = sum_r[i][SW-1] ? SW'(-sum_r[i]) : SW'(sum_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= e1_r[1] * e2_r[2];
      p_r[1] <= e1_r[2] * e2_r[1];
      p_r[2] <= e1_r[2] * e2_r[0];
      p_r[3] <= e1_r[0] * e2_r[2];
      p_r[4] <= e1_r[0] * e2_r[1];
      p_r[5] <= e1_r[1] * e2_r[0];
      for (int i = 0; i < 3; i++) begin
        cm_r[i] <= (2*SW)'(sabs[i]) * (2*SW)'(RECIP3);
        sn_r[i] <= sum_r[i][SW-1];
      end
    end
  end

  // Stage 3: cross product and signed centroid.
  logic signed [XW-1:0] c_r [3];
  logic signed [CW-1:0] cen3_r [3];
  logic                 v3_r;
  logic [2*SW-1:0]      cq [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cq[i] = cm_r[i] >> RSH;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c_r[i]    <= XW'(p_r[2*i]) - XW'(p_r[2*i+1]);
        cen3_r[i] <= sn_r[i] ? -$signed(cq[i][CW-1:0]) : $signed(cq[i][CW-1:0]);
      end
    end
  end

  // Stage 4: magnitudes and half-width partial products of the squares.
  logic [AW-1:0]       ca4_r [3];
  logic                ng4_r [3];
  logic [2*HH-1:0]     hh_r [3];
  logic [HH+HL-1:0]    hl_r [3];
  logic [2*HL-1:0]     ll_r [3];
  logic signed [CW-1:0] cen4_r [3];
  logic                v4_r;
  logic [XW-1:0]       cneg [3];
  logic [AW-1:0]       cabs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cneg[i] = -c_r[i];
      cabs[i] = c_r[i][XW-1] ? cneg[i][AW-1:0] : c_r[i][AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ca4_r[i]  <= cabs[i];
        ng4_r[i]  <= c_r[i][XW-1];
        hh_r[i]   <= (2*HH)'(cabs[i][AW-1:HL]) * (2*HH)'(cabs[i][AW-1:HL]);
        hl_r[i]   <= (HH+HL)'(cabs[i][AW-1:HL]) * (HH+HL)'(cabs[i][HL-1:0]);
        ll_r[i]   <= (2*HL)'(cabs[i][HL-1:0]) * (2*HL)'(cabs[i][HL-1:0]);
        cen4_r[i] <= cen3_r[i];
      end
    end
  end

  // Stage 5: squares.
  logic [SQW-1:0]       sq_r [3];
  logic [AW-1:0]        ca5_r [3];
  logic                 ng5_r [3];
  logic signed [CW-1:0] cen5_r [3];
  logic                 v5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i]   <= (SQW'(hh_r[i]) << (2 * HL)) + (SQW'(hl_r[i]) << (HL + 1))
                     + SQW'(ll_r[i]);
        ca5_r[i]  <= ca4_r[i];
        ng5_r[i]  <= ng4_r[i];
        cen5_r[i] <= cen4_r[i];
      end
    end
  end

  // Stage 6: sum of squares.
  logic [2*MW-1:0]      ss_r;
  logic [AW-1:0]        ca6_r [3];
  logic                 ng6_r [3];
  logic signed [CW-1:0] cen6_r [3];
  logic                 v6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ss_r <= (2*MW)'(sq_r[0]) + (2*MW)'(sq_r[1]) + (2*MW)'(sq_r[2]);
      for (int i = 0; i < 3; i++) begin
        ca6_r[i]  <= ca5_r[i];
        ng6_r[i]  <= ng5_r[i];
        cen6_r[i] <= cen5_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // Square root of the summed squares.
  tcna_pkg::tcna_ctl_t sq_ctl;
  logic [SB1W-1:0]     sb1_in;
  logic [SB1W-1:0]     sb1_out;
  logic                rt_vld;
  logic [MW-1:0]       mag;

  assign sq_ctl.en  = en;
  assign sq_ctl.vld = v6_r;
  assign sb1_in = {cen6_r[2], cen6_r[1], cen6_r[0], ca6_r[2], ca6_r[1], ca6_r[0],
                   ng6_r[2], ng6_r[1], ng6_r[0]};

  tcna_isqrt #(
    .RW  (MW),
    .SBW (SB1W)
  ) u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (sq_ctl),
    .rad     (ss_r),
    .sb_in   (sb1_in),
    .out_vld (rt_vld),
    .root    (mag),
    .sb_out  (sb1_out)
  );

  // Normal components: |c| * 2^NF / magnitude.
  tcna_pkg::tcna_ctl_t     dv_ctl;
  logic [2:0][AW+NF-1:0]   num;
  logic [SB2W-1:0]         sb2_in;
  logic [SB2W-1:0]         sb2_out;
  logic                    dv_vld;
  logic [2:0][QW-1:0]      quo;

  assign dv_ctl.en  = en;
  assign dv_ctl.vld = rt_vld;
  for (genvar l = 0; l < 3; l++) begin : g_num
    assign num[l] = {sb1_out[3 + l*AW +: AW], {NF{1'b0}}};
  end
  assign sb2_in = {sb1_out[SB1W-1 -: 3*CW], sb1_out[2:0], mag};

  tcna_div #(
    .NUMW (AW + NF),
    .DENW (MW),
    .QW   (QW),
    .SBW  (SB2W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (dv_ctl),
    .num     (num),
    .den     (mag),
    .sb_in   (sb2_in),
    .out_vld (dv_vld),
    .quo     (quo),
    .sb_out  (sb2_out)
  );

  // Output register.
  logic                 out_valid_r;
  logic signed [CW-1:0] cen_r [3];
  logic signed [NW-1:0] nrm_r [3];
  logic [AW-1:0]        area_r;
  logic                 deg_r;
  logic [MW-1:0]        fmag;
  logic                 fdeg;
  logic signed [NW-1:0] fq [3];

  assign fmag = sb2_out[MW-1:0];
  assign fdeg = fmag == '0;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fq[i] = $signed(NW'(quo[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cen_r[i] <= $signed(sb2_out[MW + 3 + i*CW +: CW]);
        if (fdeg) begin
          nrm_r[i] <= '0;
        end else begin
          nrm_r[i] <= sb2_out[MW + i] ? -fq[i] : fq[i];
        end
      end
      area_r <= fdeg ? '0 : fmag[MW-1:1];
      deg_r  <= fdeg;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_centroid_x = cen_r[0];
  assign out_centroid_y = cen_r[1];
  assign out_centroid_z = cen_r[2];
  assign out_normal_x   = nrm_r[0];
  assign out_normal_y   = nrm_r[1];
  assign out_normal_z   = nrm_r[2];
  assign out_tri_area   = area_r;
  assign out_degenerate = deg_r;

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && deg_r |-> area_r == '0 && nrm_r[0] == '0 && nrm_r[1] == '0
    && nrm_r[2] == '0)
    else $error("degenerate word carries a nonzero normal or area");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> nrm_r[0] <= NMAX && nrm_r[0] >= -NMAX && nrm_r[1] <= NMAX
    && nrm_r[1] >= -NMAX && nrm_r[2] <= NMAX && nrm_r[2] >= -NMAX)
    else $error("normal component exceeds unit magnitude");

  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid_r && !dv_vld && !rt_vld)
    else $error("pipeline holds a valid word right after reset");

endmodule

// ===== bench/triangle_centroid_normal_area_unit_test.sv =====
`timescale 1ns / 1ps

module triangle_centroid_normal_area_unit_test;

  localparam int CB = 20;
  localparam int NF = 14;
  localparam int LATENCY = 2*CB + NF + 10;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_TRIS = 1300;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct {
    coord_t v[9];
    bit     drain_first;
  } tri_word_t;

  typedef struct {
    coord_t               cen[3];
    logic signed [NF+1:0] nrm[3];
    logic [2*CB:0]        area;
    logic                 degen;
  } geom_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t in_v0_x = '0, in_v0_y = '0, in_v0_z = '0;
  coord_t in_v1_x = '0, in_v1_y = '0, in_v1_z = '0;
  coord_t in_v2_x = '0, in_v2_y = '0, in_v2_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  coord_t out_centroid_x, out_centroid_y, out_centroid_z;
  logic signed [NF+1:0] out_normal_x, out_normal_y, out_normal_z;
  logic [2*CB:0] out_tri_area;
  logic out_degenerate;

  tri_word_t pending_tris[$];
  geom_t     expected_geom[$];
  int        gap_left = 0;
  int        fail_cnt = 0;
  int        idle_cycles = 0;
  bit        gaps_on = 1'b1;

  always #5 clk = ~clk;

  triangle_centroid_normal_area_unit #(.COORD_BITS(CB), .NORMAL_FRAC_BITS(NF)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_v0_x(in_v0_x), .in_v0_y(in_v0_y), .in_v0_z(in_v0_z),
    .in_v1_x(in_v1_x), .in_v1_y(in_v1_y), .in_v1_z(in_v1_z),
    .in_v2_x(in_v2_x), .in_v2_y(in_v2_y), .in_v2_z(in_v2_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_centroid_x(out_centroid_x), .out_centroid_y(out_centroid_y),
    .out_centroid_z(out_centroid_z),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y), .out_normal_z(out_normal_z),
    .out_tri_area(out_tri_area), .out_degenerate(out_degenerate)
  );

  function automatic geom_t triangle_geometry(tri_word_t t);
    longint v[9];
    longint e1[3], e2[3], c[3];
    longint s;
    logic [127:0] sq, a, cand, q;
    logic [63:0] mag;
    geom_t r;
    for (int i = 0; i < 9; i++) v[i] = t.v[i];
    for (int i = 0; i < 3; i++) begin
      s = v[i] + v[3+i] + v[6+i];
      r.cen[i] = coord_t'(s / 3);
      e1[i] = v[3+i] - v[i];
      e2[i] = v[6+i] - v[i];
    end
    c[0] = e1[1]*e2[2] - e1[2]*e2[1];
    c[1] = e1[2]*e2[0] - e1[0]*e2[2];
    c[2] = e1[0]*e2[1] - e1[1]*e2[0];
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      a = (c[i] < 0) ? 128'(-c[i]) : 128'(c[i]);
      sq += a * a;
    end
    // Bitwise floor square root.
    mag = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = 128'(mag | (64'd1 << b));
      if (cand * cand <= sq) mag = cand[63:0];
    end
    r.degen = (mag == 0);
    r.area = r.degen ? '0 : (2*CB+1)'(mag >> 1);
    for (int i = 0; i < 3; i++) begin
      if (r.degen) begin
        r.nrm[i] = '0;
      end else begin
        a = (c[i] < 0) ? 128'(-c[i]) : 128'(c[i]);
        q = (a << NF) / 128'(mag);
        r.nrm[i] = (c[i] < 0) ? -(NF+2)'(q) : (NF+2)'(q);
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: a word is accepted at an edge where valid is high and stall is low.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        tri_word_t t;
        t.v = '{in_v0_x, in_v0_y, in_v0_z, in_v1_x, in_v1_y, in_v1_z,
                in_v2_x, in_v2_y, in_v2_z};
        expected_geom = {expected_geom, triangle_geometry(t)};
        gap_left = pick_gap();
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_tris.size() > 0 &&
                     (!pending_tris[0].drain_first || expected_geom.size() == 0)) begin
          tri_word_t t;
          t = pending_tris.pop_front();
          in_v0_x <= t.v[0]; in_v0_y <= t.v[1]; in_v0_z <= t.v[2];
          in_v1_x <= t.v[3]; in_v1_y <= t.v[4]; in_v1_z <= t.v[5];
          in_v2_x <= t.v[6]; in_v2_y <= t.v[7]; in_v2_z <= t.v[8];
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and result stall.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_geom.size() == 0) begin
          $error("unexpected result word");
          fail_cnt++;
        end else begin
          geom_t e;
          e = expected_geom.pop_front();
          if (out_centroid_x !== e.cen[0]) begin
            $error("centroid_x: expected %0d, got %0d", e.cen[0], out_centroid_x);
            fail_cnt++;
          end
          if (out_centroid_y !== e.cen[1]) begin
            $error("centroid_y: expected %0d, got %0d", e.cen[1], out_centroid_y);
            fail_cnt++;
          end
          if (out_centroid_z !== e.cen[2]) begin
            $error("centroid_z: expected %0d, got %0d", e.cen[2], out_centroid_z);
            fail_cnt++;
          end
          if (out_normal_x !== e.nrm[0]) begin
            $error("normal_x: expected %0d, got %0d", e.nrm[0], out_normal_x);
            fail_cnt++;
          end
          if (out_normal_y !== e.nrm[1]) begin
            $error("normal_y: expected %0d, got %0d", e.nrm[1], out_normal_y);
            fail_cnt++;
          end
          if (out_normal_z !== e.nrm[2]) begin
            $error("normal_z: expected %0d, got %0d", e.nrm[2], out_normal_z);
            fail_cnt++;
          end
          if (out_tri_area !== e.area) begin
            $error("tri_area: expected %0d, got %0d", e.area, out_tri_area);
            fail_cnt++;
          end
          if (out_degenerate !== e.degen) begin
            $error("degenerate: expected %0d, got %0d", e.degen, out_degenerate);
            fail_cnt++;
          end
        end
      end
      if (!gaps_on) out_stall <= 1'b0;
      else if ($urandom_range(0, 99) < 3) out_stall <= 1'b1;
      else if (out_stall) out_stall <= ($urandom_range(0, 99) < 85);
      else out_stall <= ($urandom_range(0, 99) < 20);
    end
  end

  // Watchdog on cycles with no accepted word on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic coord_t rand_coord(int kind);
    coord_t extremes[5] = '{coord_t'(-524288), coord_t'(524287), '0, -1, 1};
    case (kind)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 2048)) - 1024);
      default: return extremes[$urandom_range(0, 4)];
    endcase
  endfunction

  task automatic queue_tri(coord_t a[9], bit drain);
    tri_word_t t;
    t.v = a;
    t.drain_first = drain;
    pending_tris = {pending_tris, t};
  endtask

  task automatic queue_random_tri();
    coord_t a[9];
    coord_t base, d[3];
    int k, kind;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      foreach (a[i]) a[i] = rand_coord(0);
    end else if (kind < 75) begin
      // Small triangle around a random point.
      for (int i = 0; i < 3; i++) begin
        base = rand_coord(0) >>> $urandom_range(0, 8);
        a[i] = base;
        a[3+i] = base + rand_coord(1);
        a[6+i] = base + rand_coord(1);
      end
    end else if (kind < 87) begin
      // Collinear or coincident vertices.
      k = $signed($urandom_range(0, 6)) - 3;
      for (int i = 0; i < 3; i++) begin
        d[i] = rand_coord(1) >>> 2;
        a[i] = rand_coord(0) >>> 2;
        a[3+i] = a[i] + d[i];
        a[6+i] = a[i] + coord_t'(k * d[i]);
      end
    end else if (kind < 95) begin
      foreach (a[i]) a[i] = rand_coord(2);
    end else begin
      // Triangle in a plane normal to one axis.
      k = $urandom_range(0, 2);
      foreach (a[i]) a[i] = rand_coord(1);
      a[3+k] = a[k];
      a[6+k] = a[k];
    end
    queue_tri(a, 1'b0);
  endtask

  initial begin
    coord_t mx, mn;
    mx = coord_t'(524287);
    mn = coord_t'(-524288);
    queue_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b0);
    queue_tri('{mx, mx, mx, mx, mx, mx, mx, mx, mx}, 1'b0);
    queue_tri('{mn, mn, mn, mn, mn, mn, mn, mn, mn}, 1'b0);
    queue_tri('{mn, mn, mn, mx, mn, mn, mn, mx, mn}, 1'b0);
    queue_tri('{mx, mx, mx, mn, mx, mx, mx, mn, mx}, 1'b0);
    queue_tri('{mn, mn, mn, mx, mn, mx, mn, mx, mx}, 1'b0);
    queue_tri('{mx, mn, mx, mn, mx, mn, mx, mx, mn}, 1'b0);
    queue_tri('{0, 0, 0, 256, 0, 0, 0, 256, 0}, 1'b0);
    queue_tri('{0, 0, 0, 0, 256, 0, 256, 0, 0}, 1'b0);
    queue_tri('{0, 0, 0, 0, 0, 256, 0, 256, 0}, 1'b0);
    queue_tri('{0, 0, 0, 256, 0, 0, 0, 0, 256}, 1'b0);
    queue_tri('{0, 0, 0, 1, 0, 0, 0, 1, 0}, 1'b0);
    queue_tri('{0, 0, 0, 1, 1, 1, 2, 2, 2}, 1'b0);
    queue_tri('{5, -7, 9, 5, -7, 9, 5, -7, 9}, 1'b0);
    queue_tri('{-1, -1, -1, -1, -1, -1, 0, 0, 0}, 1'b0);
    queue_tri('{-1, -2, 1, 0, 0, 0, 1, 0, 0}, 1'b0);
    queue_tri('{-2, 0, 0, 0, -2, 0, 0, 0, -2}, 1'b0);
    queue_tri('{100, 200, 300, -400, 500, -600, 700, -800, 900}, 1'b0);
    queue_tri('{mx, 0, 0, 0, mx, 0, 0, 0, mx}, 1'b0);
    queue_tri('{mn, 0, 0, 0, mn, 0, 0, 0, mn}, 1'b0);
    queue_tri('{coord_t'(20'h55555), coord_t'(20'haaaaa), coord_t'(20'h55555),
                coord_t'(20'haaaaa), coord_t'(20'h55555), coord_t'(20'haaaaa),
                coord_t'(20'h0f0f0), coord_t'(20'hf0f0f), coord_t'(20'h33333)}, 1'b0);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    for (int n = 0; n < RANDOM_TRIS; n++) begin
      if (n % 300 == 150) begin
        wait (pending_tris.size() == 0);
        @(posedge clk);
        gaps_on = ~gaps_on;
      end
      // Hold the next triangle until the pipeline has drained.
      if (n == 500) begin
        coord_t a[9];
        foreach (a[i]) a[i] = rand_coord(0);
        queue_tri(a, 1'b1);
      end else begin
        queue_random_tri();
      end
      if (pending_tris.size() > 64) wait (pending_tris.size() < 16);
    end
    gaps_on = 1'b1;
    wait (pending_tris.size() == 0);
    @(posedge clk);
    wait (!in_valid && expected_geom.size() == 0);
    repeat (LATENCY + 16) @(posedge clk);
    if (fail_cnt == 0 && expected_geom.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
